FILE: src/b2q_pkg.sv
// shared constants and types for the basis to quaternion unit
package b2q_pkg;

  // default number of fraction bits of the fixed point format
  localparam int FRAC_BITS_DEF = 14;

  // component that carries the square root in the chosen branch
  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2,
    SEL_W = 2'd3
  } sel_t;

endpackage

FILE: src/b2q_sqrt.sv
// pipelined rounded integer square root, one result bit per stage
module b2q_sqrt #(
  parameter int N  = 17,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*N-1:0] rad,
  input  logic [SW-1:0]  side_in,
  output logic           out_valid,
  output logic [N:0]     root,
  output logic [SW-1:0]  side_out
);

  logic           v_r    [N+1];
  logic [N+1:0]   rem_r  [N];
  logic [N-1:0]   res_r  [N];
  logic [2*N-1:0] rad_r  [N];
  logic [SW-1:0]  side_r [N+1];
  logic [N:0]     root_r;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic           v_in;
    logic [N+1:0]   rem_in;
    logic [N-1:0]   res_in;
    logic [2*N-1:0] rad_in;
    logic [SW-1:0]  side_i;
    logic [N+1:0]   cat;
    logic [N+1:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign res_in = '0;
      assign rad_in = rad;
      assign side_i = side_in;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
      assign rad_in = rad_r[k-1];
      assign side_i = side_r[k-1];
    end

    // bring down the next two radicand bits, try 4*res+1
    assign cat   = {rem_in[N-1:0], rad_in[2*N-1 -: 2]};
    assign trial = {res_in, 2'b01};
    assign ge    = (cat >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (cat - trial) : cat;
        res_r[k]  <= {res_in[N-2:0], ge};
        rad_r[k]  <= rad_in << 2;
        side_r[k] <= side_i;
      end
    end
  end

  // round to nearest: bump when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[N] <= 1'b0;
    end else if (en) begin
      v_r[N] <= v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r    <= {1'b0, res_r[N-1]} +
                   (N+1)'((rem_r[N-1] > (N+2)'(res_r[N-1])) ? 1 : 0);
      side_r[N] <= side_r[N-1];
    end
  end

  assign out_valid = v_r[N];
  assign root      = root_r;
  assign side_out  = side_r[N];

endmodule

FILE: src/b2q_div.sv
// pipelined restoring divider, lanes share one divisor, one quotient bit per stage
module b2q_div #(
  parameter int ND    = 32,
  parameter int DW    = 18,
  parameter int LANES = 4,
  parameter int SW    = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [LANES-1:0][ND-1:0]  num,
  input  logic [DW-1:0]             den,
  input  logic [SW-1:0]             side_in,
  output logic                      out_valid,
  output logic [LANES-1:0][ND-1:0]  quo,
  output logic [SW-1:0]             side_out
);

  logic                     v_r    [ND];
  logic [LANES-1:0][DW:0]   rem_r  [ND];
  logic [LANES-1:0][ND-1:0] num_r  [ND];
  logic [DW-1:0]            den_r  [ND];
  logic [SW-1:0]            side_r [ND];

  for (genvar k = 0; k < ND; k++) begin : g_step
    logic                     v_in;
    logic [LANES-1:0][DW:0]   rem_in;
    logic [LANES-1:0][ND-1:0] num_in;
    logic [DW-1:0]            den_in;
    logic [SW-1:0]            side_i;
    logic [LANES-1:0][DW:0]   rem_nxt;
    logic [LANES-1:0][ND-1:0] num_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
      assign side_i = side_in;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
      assign side_i = side_r[k-1];
    end

    // quotient bits shift in at the bottom of the dividend word
    always_comb begin
      logic [DW:0] cat;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        cat        = {rem_in[l][DW-1:0], num_in[l][ND-1]};
        ge         = (cat >= {1'b0, den_in});
        rem_nxt[l] = ge ? (cat - {1'b0, den_in}) : cat;
        num_nxt[l] = {num_in[l][ND-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        num_r[k]  <= num_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[ND-1];
  assign quo       = num_r[ND-1];
  assign side_out  = side_r[ND-1];

endmodule

FILE: src/basis_to_quaternion_unit.sv
// top level: rotation basis to normalized quaternion, fully pipelined
//
//  channel | ports                                  | dir | handshake
//  --------+----------------------------------------+-----+-----------------
//  input   | in_right_*, in_up_*, in_forward_* (x9)  | in  | in_valid/in_ready
//  result  | out_quat_x/y/z/w (x4)                  | out | out_valid/out_ready
//
// one item enters per cycle unless a held result stalls the pipe; its depth is
//   set by the bit-per-stage square root and divider chains
// reset clears every stage valid bit; data registers are not reset
// a stalled result freezes the whole pipe in place, nothing is dropped or doubled
module basis_to_quaternion_unit #(
  parameter int FRAC_BITS = b2q_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_right_x,
  input  logic [15:0] in_right_y,
  input  logic [15:0] in_right_z,
  input  logic [15:0] in_up_x,
  input  logic [15:0] in_up_y,
  input  logic [15:0] in_up_z,
  input  logic [15:0] in_forward_x,
  input  logic [15:0] in_forward_y,
  input  logic [15:0] in_forward_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_quat_x,
  output logic [15:0] out_quat_y,
  output logic [15:0] out_quat_z,
  output logic [15:0] out_quat_w
);

  // radicand width, first root width, component width
  localparam int RW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int N1  = (RW + FRAC_BITS + 1) / 2;
  localparam int QB  = ((N1 > 17) ? N1 : 17) + 1;
  localparam int ND1 = ((17 + FRAC_BITS > N1 + 1) ? 17 + FRAC_BITS : N1 + 1) + 1;
  localparam int DW1 = N1 + 2;
  localparam int ND2 = QB + FRAC_BITS;
  localparam int DW2 = QB + 1;
  localparam longint ONE   = 64'sd1 <<< FRAC_BITS;
  localparam longint EPS   = ONE / 100000;
  localparam longint LIM_P = (ONE > 32767) ? 64'sd32767 : ONE;
  localparam longint LIM_N = (ONE > 32768) ? 64'sd32768 : ONE;
  localparam logic signed [15:0] Q_MAX = 16'(LIM_P);
  localparam logic signed [15:0] Q_MIN = 16'(-LIM_N);

  typedef struct packed {
    b2q_pkg::sel_t   sel;
    logic [3:0]      sgn;
    logic [3:0][16:0] mag;
  } sq1_side_t;

  typedef struct packed {
    b2q_pkg::sel_t sel;
    logic [3:0]    sgn;
    logic [QB-2:0] root_half;
    logic          dz;
  } dv1_side_t;

  typedef struct packed {
    logic [3:0]           sgn;
    logic [3:0][QB-2:0]   mag;
  } sq2_side_t;

  typedef struct packed {
    logic [3:0]           sgn;
    logic [3:0][QB-2:0]   mag;
    logic                 nrm;
  } dv2_side_t;

  // whole pipe advances unless a finished result is held
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------
  // front stage: branch choice, radicand, off-diagonal numerators
  // ---------------------------------------------------------------
  logic signed [15:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
  assign m00 = in_right_x;
  assign m10 = in_right_y;
  assign m20 = in_right_z;
  assign m01 = in_up_x;
  assign m11 = in_up_y;
  assign m21 = in_up_z;
  assign m02 = in_forward_x;
  assign m12 = in_forward_y;
  assign m22 = in_forward_z;

  b2q_pkg::sel_t      sel_c;
  logic signed [RW:0] rad_c;
  logic [RW-1:0]      r_c;
  logic signed [16:0] n_c [4];
  sq1_side_t          s0_side;

  always_comb begin
    logic signed [RW:0] a00, a11, a22, one_s, trace;
    logic signed [16:0] d_zy, d_xz, d_yx, s_xy, s_xz, s_yz;
    a00   = (RW+1)'(m00);
    a11   = (RW+1)'(m11);
    a22   = (RW+1)'(m22);
    one_s = (RW+1)'(ONE);
    trace = a00 + a11 + a22;
    d_zy  = 17'(m21) - 17'(m12);
    d_xz  = 17'(m02) - 17'(m20);
    d_yx  = 17'(m10) - 17'(m01);
    s_xy  = 17'(m01) + 17'(m10);
    s_xz  = 17'(m02) + 17'(m20);
    s_yz  = 17'(m12) + 17'(m21);
    // trace branch first, then largest diagonal, ties to the later one
    if (trace > 0) begin
      sel_c = b2q_pkg::SEL_W;
      rad_c = one_s + trace;
    end else if (m00 > m11 && m00 > m22) begin
      sel_c = b2q_pkg::SEL_X;
      rad_c = one_s + a00 - a11 - a22;
    end else if (m11 > m22) begin
      sel_c = b2q_pkg::SEL_Y;
      rad_c = one_s + a11 - a00 - a22;
    end else begin
      sel_c = b2q_pkg::SEL_Z;
      rad_c = one_s + a22 - a00 - a11;
    end
    r_c = rad_c[RW] ? '0 : rad_c[RW-1:0];
    for (int i = 0; i < 4; i++) begin
      n_c[i] = '0;
    end
    unique case (sel_c)
      b2q_pkg::SEL_W: begin
        n_c[0] = d_zy; n_c[1] = d_xz; n_c[2] = d_yx;
      end
      b2q_pkg::SEL_X: begin
        n_c[3] = d_zy; n_c[1] = s_xy; n_c[2] = s_xz;
      end
      b2q_pkg::SEL_Y: begin
        n_c[3] = d_xz; n_c[0] = s_xy; n_c[2] = s_yz;
      end
      b2q_pkg::SEL_Z: begin
        n_c[3] = d_yx; n_c[0] = s_xz; n_c[1] = s_yz;
      end
      default: begin
      end
    endcase
    s0_side.sel = sel_c;
    for (int i = 0; i < 4; i++) begin
      s0_side.sgn[i] = n_c[i][16];
      s0_side.mag[i] = n_c[i][16] ? 17'(~n_c[i] + 17'sd1) : n_c[i];
    end
  end

  logic            v0_r;
  logic [2*N1-1:0] rad0_r;
  sq1_side_t       side0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad0_r  <= (2*N1)'({r_c, {FRAC_BITS{1'b0}}});
      side0_r <= s0_side;
    end
  end

  // scale root: s = round(sqrt(r * one))
  logic       sq1_v;
  logic [N1:0] sq1_root;
  sq1_side_t  sq1_side;

  b2q_sqrt #(.N(N1), .SW($bits(sq1_side_t))) u_sqrt_scale (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v0_r), .rad(rad0_r), .side_in(side0_r),
    .out_valid(sq1_v), .root(sq1_root), .side_out(sq1_side)
  );

  // ---------------------------------------------------------------
  // dividend setup: |n| * one + s over 2s rounds to nearest
  // ---------------------------------------------------------------
  logic                      v1_r;
  logic [3:0][ND1-1:0]       num1_r;
  logic [DW1-1:0]            den1_r;
  dv1_side_t                 side1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= sq1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        num1_r[i] <= ND1'({sq1_side.mag[i], {FRAC_BITS{1'b0}}}) + ND1'(sq1_root);
      end
      den1_r            <= {sq1_root, 1'b0};
      side1_r.sel       <= sq1_side.sel;
      side1_r.sgn       <= sq1_side.sgn;
      side1_r.root_half <= (QB-1)'((DW1'(sq1_root) + DW1'(1)) >> 1);
      side1_r.dz        <= (sq1_root == '0);
    end
  end

  logic                dv1_v;
  logic [3:0][ND1-1:0] dv1_quo;
  dv1_side_t           dv1_side;

  b2q_div #(.ND(ND1), .DW(DW1), .LANES(4), .SW($bits(dv1_side_t))) u_div_scale (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v1_r), .num(num1_r), .den(den1_r), .side_in(side1_r),
    .out_valid(dv1_v), .quo(dv1_quo), .side_out(dv1_side)
  );

  // ---------------------------------------------------------------
  // assemble raw quaternion, the chosen lane gets round(s/2)
  // ---------------------------------------------------------------
  logic               v2_r;
  b2q_pkg::sel_t      sel2_r;
  logic [3:0]         qs2_r;
  logic [3:0][QB-2:0] qm2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= dv1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel2_r <= dv1_side.sel;
      for (int i = 0; i < 4; i++) begin
        if (dv1_side.sel == b2q_pkg::sel_t'(i)) begin
          qs2_r[i] <= 1'b0;
          qm2_r[i] <= dv1_side.root_half;
        end else begin
          qs2_r[i] <= dv1_side.sgn[i];
          qm2_r[i] <= dv1_side.dz ? '0 : dv1_quo[i][QB-2:0];
        end
      end
    end
  end

  // squares, then their sum, one register each
  logic                       v3_r;
  logic [3:0][2*(QB-1)-1:0]   sqr3_r;
  sq2_side_t                  side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sqr3_r[i] <= (2*(QB-1))'(qm2_r[i]) * (2*(QB-1))'(qm2_r[i]);
      end
      side3_r.sgn <= qs2_r;
      side3_r.mag <= qm2_r;
    end
  end

  logic           v4_r;
  logic [2*QB-1:0] sum4_r;
  sq2_side_t      side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum4_r  <= (2*QB)'(sqr3_r[0]) + (2*QB)'(sqr3_r[1]) +
                 (2*QB)'(sqr3_r[2]) + (2*QB)'(sqr3_r[3]);
      side4_r <= side3_r;
    end
  end

  // length root
  logic      sq2_v;
  logic [QB:0] sq2_root;
  sq2_side_t sq2_side;

  b2q_sqrt #(.N(QB), .SW($bits(sq2_side_t))) u_sqrt_len (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v4_r), .rad(sum4_r), .side_in(side4_r),
    .out_valid(sq2_v), .root(sq2_root), .side_out(sq2_side)
  );

  // ---------------------------------------------------------------
  // normalize setup: |q| * one + len/2 over len, skipped for tiny len
  // ---------------------------------------------------------------
  logic                v5_r;
  logic [3:0][ND2-1:0] num5_r;
  logic [DW2-1:0]      den5_r;
  dv2_side_t           side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= sq2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        num5_r[i] <= ND2'({sq2_side.mag[i], {FRAC_BITS{1'b0}}}) + ND2'(sq2_root >> 1);
      end
      den5_r      <= sq2_root;
      side5_r.sgn <= sq2_side.sgn;
      side5_r.mag <= sq2_side.mag;
      side5_r.nrm <= (sq2_root > DW2'(EPS));
    end
  end

  logic                dv2_v;
  logic [3:0][ND2-1:0] dv2_quo;
  dv2_side_t           dv2_side;

  b2q_div #(.ND(ND2), .DW(DW2), .LANES(4), .SW($bits(dv2_side_t))) u_div_norm (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v5_r), .num(num5_r), .den(den5_r), .side_in(side5_r),
    .out_valid(dv2_v), .quo(dv2_quo), .side_out(dv2_side)
  );

  // ---------------------------------------------------------------
  // output register: pick normalized or raw, clamp, restore sign
  // ---------------------------------------------------------------
  logic [3:0][15:0] res_c;

  always_comb begin
    logic [ND2-1:0] mag, lim;
    logic [15:0]    m16;
    for (int i = 0; i < 4; i++) begin
      mag = dv2_side.nrm ? dv2_quo[i] : ND2'(dv2_side.mag[i]);
      lim = dv2_side.sgn[i] ? ND2'(LIM_N) : ND2'(LIM_P);
      if (mag > lim) begin
        mag = lim;
      end
      m16      = mag[15:0];
      res_c[i] = dv2_side.sgn[i] ? (~m16 + 16'd1) : m16;
    end
  end

  logic        out_valid_r;
  logic [15:0] qx_r, qy_r, qz_r, qw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r <= res_c[0];
      qy_r <= res_c[1];
      qz_r <= res_c[2];
      qw_r <= res_c[3];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_quat_x = qx_r;
  assign out_quat_y = qy_r;
  assign out_quat_z = qz_r;
  assign out_quat_w = qw_r;

  // chosen branch always gives r >= one, so the scale is never zero
  a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> !side1_r.dz)
    else $error("zero scale reached the divider");

  // the root-derived component is never negative
  a_large_pos: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> !qs2_r[sel2_r])
    else $error("large component carries a sign");

  // x and w results stay inside the unit range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_quat_x) <= Q_MAX && $signed(out_quat_x) >= Q_MIN &&
                   $signed(out_quat_w) <= Q_MAX && $signed(out_quat_w) >= Q_MIN))
    else $error("quaternion component out of range");

endmodule

FILE: test/basis_to_quaternion_unit_test.sv
// self-checking testbench for the basis to quaternion unit
module basis_to_quaternion_unit_test;

  // fixed point scale of the block
  localparam int FB = b2q_pkg::FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;
  // field codes that show up in the stimulus table
  localparam logic [15:0] P = 16'h4000;
  localparam logic [15:0] N = 16'hC000;
  localparam logic [15:0] Z = 16'h0000;
  localparam int N_RANDOM = 1350;
  localparam int LATENCY = 108;

  // one quaternion, index 0..3 is x, y, z, w
  typedef logic [0:3][15:0] quat_t;
  // one basis, index 0..8 is right xyz, up xyz, forward xyz
  typedef logic [0:8][15:0] basis_t;

  typedef struct packed {
    basis_t m;
    logic   known;
    quat_t  q;
  } row_t;

  localparam int N_ROWS = 16;
  // expected result typed in only where it is obvious; others go to the predictor
  localparam row_t ROWS [N_ROWS] = '{
    '{'{P, Z, Z, Z, P, Z, Z, Z, P}, 1'b1, '{Z, Z, Z, P}},  // identity, trace branch
    '{'{Z, Z, Z, Z, Z, Z, Z, Z, Z}, 1'b1, '{Z, Z, P, Z}},  // zero basis falls to z
    '{'{P, Z, Z, Z, N, Z, Z, Z, N}, 1'b1, '{P, Z, Z, Z}},  // x branch
    '{'{N, Z, Z, Z, P, Z, Z, Z, N}, 1'b1, '{Z, P, Z, Z}},  // y branch
    '{'{N, Z, Z, Z, N, Z, Z, Z, P}, 1'b1, '{Z, Z, P, Z}},  // z branch
    '{'{N, Z, Z, Z, N, Z, Z, Z, N}, 1'b0, '0},             // all-equal tie
    '{'{Z, Z, Z, Z, Z, Z, Z, Z, N}, 1'b0, '0},             // x/y tie goes to y
    '{'{P, Z, Z, Z, P, Z, Z, Z, N}, 1'b0, '0},             // positive trace, one flip
    '{'{Z, P, Z, N, Z, Z, Z, Z, P}, 1'b0, '0},             // quarter turn about z
    '{'{Z, Z, N, Z, P, Z, P, Z, Z}, 1'b0, '0},             // quarter turn about y
    '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
        16'h7FFF, 16'h7FFF}, 1'b0, '0},                    // max positive
    '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
        16'h8000, 16'h8000}, 1'b0, '0},                    // max negative
    '{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
        16'hAAAA, 16'h5555}, 1'b0, '0},                    // alternating bits
    '{'{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
        16'h8000, 16'h8000}, 1'b0, '0},                    // out of range mix
    '{'{16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF,
        16'h0001, 16'hFFFF}, 1'b0, '0},                    // one lsb around zero
    '{'{P, P, P, N, N, N, P, N, P}, 1'b0, '0}              // off-diagonal extremes
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  basis_t basis_drv = '0;
  logic in_ready, out_valid;
  quat_t quat_seen;

  quat_t pending_quats [$];
  int    n_errors = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  basis_to_quaternion_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_right_x  (basis_drv[0]),
    .in_right_y  (basis_drv[1]),
    .in_right_z  (basis_drv[2]),
    .in_up_x     (basis_drv[3]),
    .in_up_y     (basis_drv[4]),
    .in_up_z     (basis_drv[5]),
    .in_forward_x(basis_drv[6]),
    .in_forward_y(basis_drv[7]),
    .in_forward_z(basis_drv[8]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_quat_x  (quat_seen[0]),
    .out_quat_y  (quat_seen[1]),
    .out_quat_z  (quat_seen[2]),
    .out_quat_w  (quat_seen[3])
  );

  // signed quotient rounded to nearest, ties away from zero; zero divisor gives zero
  function automatic longint div_round(longint num, longint den);
    longint mag;
    longint quo;
    if (den <= 0) return 0;
    mag = (num < 0) ? -num : num;
    quo = (mag + den / 2) / den;
    return (num < 0) ? -quo : quo;
  endfunction

  // bit-per-step square root, then rounded to the nearest integer
  function automatic longint unsigned sqrt_round(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    longint unsigned rem;
    res = 0;
    rem = v;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (v - res * res > res) res++;
    return res;
  endfunction

  function automatic logic [15:0] clamp_q(longint v);
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // predicted quaternion for one basis
  function automatic quat_t basis_to_quat(basis_t b);
    longint m [9];
    longint q [4];
    longint trace, rad, s, sc, len;
    longint unsigned sum;
    b2q_pkg::sel_t sel;
    quat_t  res;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(b[i]));
    // m[row + 3*col]: right=(m00,m10,m20), up=(m01,m11,m21), fwd=(m02,m12,m22)
    trace = m[0] + m[4] + m[8];
    if (trace > 0) begin
      sel = b2q_pkg::SEL_W;
      rad = ONE + trace;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      sel = b2q_pkg::SEL_X;
      rad = ONE + m[0] - m[4] - m[8];
    end else if (m[4] > m[8]) begin
      sel = b2q_pkg::SEL_Y;
      rad = ONE + m[4] - m[0] - m[8];
    end else begin
      sel = b2q_pkg::SEL_Z;
      rad = ONE + m[8] - m[0] - m[4];
    end
    if (rad < 0) rad = 0;
    s = longint'(sqrt_round(longint'(rad * ONE)));
    sc = 2 * s;
    case (sel)
      b2q_pkg::SEL_W: begin
        q[0] = div_round((m[5] - m[7]) * ONE, sc);
        q[1] = div_round((m[6] - m[2]) * ONE, sc);
        q[2] = div_round((m[1] - m[3]) * ONE, sc);
        q[3] = div_round(s, 2);
      end
      b2q_pkg::SEL_X: begin
        q[3] = div_round((m[5] - m[7]) * ONE, sc);
        q[0] = div_round(s, 2);
        q[1] = div_round((m[3] + m[1]) * ONE, sc);
        q[2] = div_round((m[6] + m[2]) * ONE, sc);
      end
      b2q_pkg::SEL_Y: begin
        q[3] = div_round((m[6] - m[2]) * ONE, sc);
        q[0] = div_round((m[3] + m[1]) * ONE, sc);
        q[1] = div_round(s, 2);
        q[2] = div_round((m[7] + m[5]) * ONE, sc);
      end
      default: begin
        q[3] = div_round((m[1] - m[3]) * ONE, sc);
        q[0] = div_round((m[6] + m[2]) * ONE, sc);
        q[1] = div_round((m[7] + m[5]) * ONE, sc);
        q[2] = div_round(s, 2);
      end
    endcase
    sum = 0;
    for (int i = 0; i < 4; i++) sum += longint'(q[i] * q[i]);
    len = longint'(sqrt_round(sum));
    // too short a quaternion passes through unnormalized
    if (len > ONE / 100000) begin
      for (int i = 0; i < 4; i++) q[i] = div_round(q[i] * ONE, len);
    end
    for (int i = 0; i < 4; i++) res[i] = clamp_q(q[i]);
    return res;
  endfunction

  function automatic logic [15:0] small_noise(int amp);
    return 16'($signed(int'($urandom_range(2 * amp, 0)) - amp));
  endfunction

  // random basis: mostly near-rotations (signed permutations with noise),
  // plus in-range noise and raw 16-bit patterns
  function automatic basis_t rand_basis();
    basis_t b;
    int     perm [3];
    int     kind, amp, t, j;
    kind = $urandom_range(9, 0);
    if (kind < 6) begin
      perm = '{0, 1, 2};
      for (int i = 2; i > 0; i--) begin
        j = $urandom_range(i, 0);
        t = perm[i];
        perm[i] = perm[j];
        perm[j] = t;
      end
      amp = ($urandom_range(3, 0) == 0) ? 6000 : 800;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (r == perm[c]) begin
            t = ($urandom_range(1, 0) ? 16384 : -16384) + int'($signed(small_noise(amp)));
            if (t > 16384) t = 16384;
            if (t < -16384) t = -16384;
            b[3 * c + r] = 16'(t);
          end else begin
            b[3 * c + r] = small_noise(amp);
          end
        end
      end
    end else if (kind < 8) begin
      for (int i = 0; i < 9; i++) b[i] = small_noise(16384);
    end else begin
      for (int i = 0; i < 9; i++) b[i] = 16'($urandom);
    end
    return b;
  endfunction

  // offer one basis from the current edge until it is taken; queue its result
  task automatic send_basis(basis_t b, logic known, quat_t q);
    basis_drv <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_quats.push_back(known ? q : basis_to_quat(b));
  endtask

  // sender: bursts of back-to-back items separated by random gaps
  int burst_left = 0;
  task automatic sender_pause();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(20, 0);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // receiver: phases of always ready, random stalls and long stalls
  int rx_mode = 0;
  int rx_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_quats.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, quat_seen);
        n_errors++;
      end else begin
        quat_t want;
        want = pending_quats.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (want[i] !== quat_seen[i]) begin
            $display("%0t: quat component %0d expected %h actual %h",
                     $time, i, want[i], quat_seen[i]);
            n_errors++;
          end
        end
      end
    end
    if (rx_left == 0) begin
      rx_mode = $urandom_range(2, 0);
      rx_left = $urandom_range(60, 5);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(1, 0);
      default: out_ready <= ($urandom_range(5, 0) == 0);
    endcase
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed table first
    for (int i = 0; i < N_ROWS; i++) begin
      send_basis(ROWS[i].m, ROWS[i].known, ROWS[i].q);
      sender_pause();
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      send_basis(rand_basis(), 1'b0, '0);
      sender_pause();
    end
    in_valid <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk);
    // let any stray result show up
    repeat (2 * LATENCY) @(posedge clk);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/b2q_pkg.sv
src/b2q_sqrt.sv
src/b2q_div.sv
src/basis_to_quaternion_unit.sv
test/basis_to_quaternion_unit_test.sv
